// File: rtl/core/nearest_sorted_distance_max_top_defines.svh
// Assertion macros for the nearest sorted distance block.
// Included by the RTL files that carry concurrent assertions; expects clk_i and rst_ni.
`ifndef NEAREST_SORTED_DISTANCE_MAX_TOP_DEFINES_SVH
`define NEAREST_SORTED_DISTANCE_MAX_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check on every rising edge outside reset.
`define NSDM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check on every rising edge, reset included.
`define NSDM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define NSDM_ASSERT(name, prop, msg)
`define NSDM_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// File: rtl/core/nsdm_pkg.sv
// Shared types and constants for the nearest sorted distance block.
// No dependencies; imported by the interfaces, the cells, the control and the top level.
`default_nettype none
package nsdm_pkg;

  localparam int DEF_STORE_DEPTH = 1024;
  localparam int DEF_POS_WIDTH   = 32;
  // cells whose candidates are collected per scan cycle
  localparam int SCAN_LANES      = 64;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;    // sorted insert of pos into the chain
    logic load;   // capture floor and ceiling candidates
    logic shift;  // advance candidates toward the chain end
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/nsdm_ifs.sv
// Valid/ready channel interfaces for items in and results out.
// Depends on nsdm_pkg for the default position width.
`default_nettype none
interface nsdm_in_if #(
  parameter int POS_WIDTH = nsdm_pkg::DEF_POS_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [POS_WIDTH-1:0] position;

  modport source (output valid, output opcode, output position, input ready);
  modport sink   (input valid, input opcode, input position, output ready);
endinterface

interface nsdm_out_if #(
  parameter int POS_WIDTH = nsdm_pkg::DEF_POS_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [POS_WIDTH-1:0] nearest_distance;
  logic [POS_WIDTH-1:0] max_distance;
  logic                 max_unbounded;
  logic                 max_valid;

  modport source (output valid, output status, output nearest_distance,
                  output max_distance, output max_unbounded, output max_valid,
                  input ready);
  modport sink   (input valid, input status, input nearest_distance,
                  input max_distance, input max_unbounded, input max_valid,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/core/nearest_sorted_distance_max_top.sv
// Top level of the nearest sorted distance block: chain of sorted cells plus sequencer.
// Depends on nsdm_pkg, nsdm_ifs, nsdm_cell and nsdm_ctrl.
//
//   channel  dir  payload                                   handshake
//   in_i     in   opcode, position                          valid/ready
//   out_o    out  status, nearest_distance, max_distance,   valid/ready
//                 max_unbounded, max_valid
//
// One item at a time. A clear or an insert passes through EXEC and RESP; a query
// passes through EXEC, the candidate scan, DIST, MAXUP and RESP. The scan collects
// LANES cells per cycle from the chain end (SCAN_LANES, or the whole store when it
// is smaller). The result is shown and the input freed in the same cycle. An insert
// updates every cell of the chain in parallel, in the EXEC state.
// Reset is asynchronous, active low, and empties the store at once (count only).
// A result waits in the output register while the next item is accepted; a
// stalled output holds the sequencer before it overwrites that register.
`default_nettype none
module nearest_sorted_distance_max_top #(
  parameter int STORE_DEPTH = nsdm_pkg::DEF_STORE_DEPTH,
  parameter int POS_WIDTH   = nsdm_pkg::DEF_POS_WIDTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  nsdm_in_if.sink     in_i,
  nsdm_out_if.source  out_o
);
  import nsdm_pkg::*;

  localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
  // lanes collected per scan cycle, and the number of scan steps that drain the chain
  localparam int LANES    = (SCAN_LANES < STORE_DEPTH) ? SCAN_LANES : STORE_DEPTH;
  localparam int NUM_SCAN = (STORE_DEPTH + LANES - 1) / LANES;

  cell_cmd_t             cmd;
  logic [POS_WIDTH-1:0]  pos;
  logic [CNT_W-1:0]      count;

  logic [POS_WIDTH-1:0]  val   [STORE_DEPTH];
  logic                  gt    [STORE_DEPTH];
  logic                  lt    [STORE_DEPTH];
  logic                  le    [STORE_DEPTH];
  logic [POS_WIDTH-1:0]  fcand [STORE_DEPTH];
  logic                  fvld  [STORE_DEPTH];
  logic [POS_WIDTH-1:0]  ccand [STORE_DEPTH];
  logic                  cvld  [STORE_DEPTH];

  logic [POS_WIDTH-1:0]  fcol, ccol;
  logic                  fcol_vld, ccol_vld;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic [POS_WIDTH-1:0] val_left, fcand_in, ccand_in;
    logic                 gt_left, lt_left, le_right, fvld_in, cvld_in;

    // chain ends: nothing left of cell 0, ceiling search starts there
    if (i == 0) begin : g_head
      assign val_left = '0;
      assign gt_left  = 1'b0;
      assign lt_left  = 1'b1;
    end else begin : g_link
      assign val_left = val[i-1];
      assign gt_left  = gt[i-1];
      assign lt_left  = lt[i-1];
    end

    if (i == STORE_DEPTH - 1) begin : g_tail
      assign le_right = 1'b0;
    end else begin : g_next
      assign le_right = le[i+1];
    end

    // candidates advance LANES cells per scan cycle; zeros enter at the head
    if (i < LANES) begin : g_fill
      assign fcand_in = '0;
      assign fvld_in  = 1'b0;
      assign ccand_in = '0;
      assign cvld_in  = 1'b0;
    end else begin : g_hop
      assign fcand_in = fcand[i-LANES];
      assign fvld_in  = fvld[i-LANES];
      assign ccand_in = ccand[i-LANES];
      assign cvld_in  = cvld[i-LANES];
    end

    nsdm_cell #(
      .STORE_DEPTH (STORE_DEPTH),
      .POS_WIDTH   (POS_WIDTH),
      .IDX         (i),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .pos_i      (pos),
      .count_i    (count),
      .val_left_i (val_left),
      .gt_left_i  (gt_left),
      .lt_left_i  (lt_left),
      .le_right_i (le_right),
      .fcand_in_i (fcand_in),
      .fvld_in_i  (fvld_in),
      .ccand_in_i (ccand_in),
      .cvld_in_i  (cvld_in),
      .val_o      (val[i]),
      .gt_o       (gt[i]),
      .lt_o       (lt[i]),
      .le_o       (le[i]),
      .fcand_o    (fcand[i]),
      .fvld_o     (fvld[i]),
      .ccand_o    (ccand[i]),
      .cvld_o     (cvld[i])
    );
  end

  // At most one cell holds each candidate, so OR the lanes at the chain end.
  always_comb begin
    fcol     = '0;
    ccol     = '0;
    fcol_vld = 1'b0;
    ccol_vld = 1'b0;
    for (int j = STORE_DEPTH - LANES; j < STORE_DEPTH; j++) begin
      fcol     = fcol | fcand[j];
      ccol     = ccol | ccand[j];
      fcol_vld = fcol_vld | fvld[j];
      ccol_vld = ccol_vld | cvld[j];
    end
  end

  nsdm_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .POS_WIDTH   (POS_WIDTH),
    .NUM_SCAN    (NUM_SCAN),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .cmd_o   (cmd),
    .pos_o   (pos),
    .count_o (count),
    .fcol_i  (fcol),
    .fvld_i  (fcol_vld),
    .ccol_i  (ccol),
    .cvld_i  (ccol_vld)
  );

endmodule
`default_nettype wire

// File: rtl/core/nsdm_cell.sv
// One cell of the sorted chain: holds one stored position and its query candidates.
// Depends on nsdm_pkg for the command struct.
`default_nettype none
module nsdm_cell #(
  parameter int STORE_DEPTH = nsdm_pkg::DEF_STORE_DEPTH,
  parameter int POS_WIDTH   = nsdm_pkg::DEF_POS_WIDTH,
  parameter int IDX         = 0,
  parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire nsdm_pkg::cell_cmd_t cmd_i,
  input  wire [POS_WIDTH-1:0]   pos_i,
  input  wire [CNT_W-1:0]       count_i,
  input  wire [POS_WIDTH-1:0]   val_left_i,
  input  wire                   gt_left_i,
  input  wire                   lt_left_i,
  input  wire                   le_right_i,
  input  wire [POS_WIDTH-1:0]   fcand_in_i,
  input  wire                   fvld_in_i,
  input  wire [POS_WIDTH-1:0]   ccand_in_i,
  input  wire                   cvld_in_i,
  output logic [POS_WIDTH-1:0]  val_o,
  output logic                  gt_o,
  output logic                  lt_o,
  output logic                  le_o,
  output logic [POS_WIDTH-1:0]  fcand_o,
  output logic                  fvld_o,
  output logic [POS_WIDTH-1:0]  ccand_o,
  output logic                  cvld_o
);
  import nsdm_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [POS_WIDTH-1:0] val_q, val_d;
  logic [POS_WIDTH-1:0] fcand_q, fcand_d, ccand_q, ccand_d;
  logic                 fvld_q, fvld_d, cvld_q, cvld_d;
  logic                 occ, floor_hit, ceil_hit;

  assign occ  = IDX_C < count_i;
  assign gt_o = occ && (val_q > pos_i);
  assign lt_o = occ && (val_q < pos_i);
  assign le_o = occ && !gt_o;

  // floor: last cell not above pos; ceiling: first cell not below pos
  assign floor_hit = le_o && !le_right_i;
  assign ceil_hit  = occ && !lt_o && lt_left_i;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (gt_left_i) begin
        val_d = val_left_i;
      end else if (gt_o || (IDX_C == count_i)) begin
        val_d = pos_i;
      end
    end
  end

  always_comb begin
    fcand_d = fcand_q;
    fvld_d  = fvld_q;
    ccand_d = ccand_q;
    cvld_d  = cvld_q;
    if (cmd_i.load) begin
      fcand_d = floor_hit ? val_q : '0;
      fvld_d  = floor_hit;
      ccand_d = ceil_hit ? val_q : '0;
      cvld_d  = ceil_hit;
    end else if (cmd_i.shift) begin
      fcand_d = fcand_in_i;
      fvld_d  = fvld_in_i;
      ccand_d = ccand_in_i;
      cvld_d  = cvld_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    fcand_q <= fcand_d;
    fvld_q  <= fvld_d;
    ccand_q <= ccand_d;
    cvld_q  <= cvld_d;
  end

  assign val_o   = val_q;
  assign fcand_o = fcand_q;
  assign fvld_o  = fvld_q;
  assign ccand_o = ccand_q;
  assign cvld_o  = cvld_q;

endmodule
`default_nettype wire

// File: rtl/core/nsdm_ctrl.sv
// Sequencer for the nearest sorted distance block: handshakes, count, running maximum.
// Depends on nsdm_pkg, nsdm_ifs and the assertion macro header.
`default_nettype none
`include "nearest_sorted_distance_max_top_defines.svh"
module nsdm_ctrl #(
  parameter int STORE_DEPTH = nsdm_pkg::DEF_STORE_DEPTH,
  parameter int POS_WIDTH   = nsdm_pkg::DEF_POS_WIDTH,
  parameter int NUM_SCAN    = 1,
  parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  nsdm_in_if.sink              in_i,
  nsdm_out_if.source           out_o,
  output nsdm_pkg::cell_cmd_t  cmd_o,
  output logic [POS_WIDTH-1:0] pos_o,
  output logic [CNT_W-1:0]     count_o,
  input  wire [POS_WIDTH-1:0]  fcol_i,
  input  wire                  fvld_i,
  input  wire [POS_WIDTH-1:0]  ccol_i,
  input  wire                  cvld_i
);
  import nsdm_pkg::*;

  localparam int                SCAN_W  = (NUM_SCAN > 1) ? $clog2(NUM_SCAN) : 1;
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(NUM_SCAN - 1);
  localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(STORE_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DIST  = 6'b001000,
    S_MAXUP = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           op_q, op_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [POS_WIDTH-1:0] max_q, max_d;
  logic                 unb_q, unb_d, seen_q, seen_d;
  logic [SCAN_W-1:0]    scan_q, scan_d;
  logic [POS_WIDTH-1:0] facc_q, facc_d, cacc_q, cacc_d;
  logic                 fhave_q, fhave_d, chave_q, chave_d;
  logic [POS_WIDTH-1:0] dist_q, dist_d;
  logic [1:0]           res_status_q, res_status_d;
  logic [POS_WIDTH-1:0] res_dist_q, res_dist_d;
  logic                 ovalid_q, ovalid_d;
  logic [1:0]           ostatus_q, ostatus_d;
  logic [POS_WIDTH-1:0] odist_q, odist_d, omax_q, omax_d;
  logic                 ounb_q, ounb_d, oseen_q, oseen_d;
  logic [POS_WIDTH-1:0] fdist, cdist;
  logic                 in_fire;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign fdist = pos_q - facc_q;
  assign cdist = cacc_q - pos_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    pos_d        = pos_q;
    count_d      = count_q;
    max_d        = max_q;
    unb_d        = unb_q;
    seen_d       = seen_q;
    scan_d       = scan_q;
    facc_d       = facc_q;
    cacc_d       = cacc_q;
    fhave_d      = fhave_q;
    chave_d      = chave_q;
    dist_d       = dist_q;
    res_status_d = res_status_q;
    res_dist_d   = res_dist_q;
    ovalid_d     = ovalid_q;
    ostatus_d    = ostatus_q;
    odist_d      = odist_q;
    omax_d       = omax_q;
    ounb_d       = ounb_q;
    oseen_d      = oseen_q;
    cmd_o        = '0;

    // drop the shown result once taken
    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = in_i.opcode;
          pos_d   = in_i.position;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ST_OK;
        res_dist_d   = '0;
        state_d      = S_RESP;
        case (op_q)
          OP_CLEAR: begin
            count_d = '0;
            max_d   = '0;
            unb_d   = 1'b0;
            seen_d  = 1'b0;
          end
          OP_INSERT: begin
            if (count_q >= DEPTH_C) begin
              res_status_d = ST_FULL;
            end else begin
              cmd_o.ins = 1'b1;
              count_d   = count_q + 1'b1;
            end
          end
          OP_QUERY: begin
            seen_d = 1'b1;
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
              unb_d        = 1'b1;
            end else begin
              cmd_o.load = 1'b1;
              scan_d     = '0;
              facc_d     = '0;
              cacc_d     = '0;
              fhave_d    = 1'b0;
              chave_d    = 1'b0;
              state_d    = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        // collect the lanes at the chain end, then advance the chain
        cmd_o.shift = 1'b1;
        facc_d      = facc_q | fcol_i;
        cacc_d      = cacc_q | ccol_i;
        fhave_d     = fhave_q | fvld_i;
        chave_d     = chave_q | cvld_i;
        if (scan_q == SCAN_LAST) begin
          state_d = S_DIST;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_DIST: begin
        if (!fhave_q) begin
          dist_d = cdist;
        end else if (chave_q && (cdist < fdist)) begin
          dist_d = cdist;
        end else begin
          dist_d = fdist;
        end
        state_d = S_MAXUP;
      end
      S_MAXUP: begin
        res_dist_d = dist_q;
        if (dist_q > max_q) begin
          max_d = dist_q;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d  = 1'b1;
          ostatus_d = res_status_q;
          odist_d   = res_dist_q;
          omax_d    = max_q;
          ounb_d    = unb_q;
          oseen_d   = seen_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      max_q    <= '0;
      unb_q    <= 1'b0;
      seen_q   <= 1'b0;
      scan_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      max_q    <= max_d;
      unb_q    <= unb_d;
      seen_q   <= seen_d;
      scan_q   <= scan_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    pos_q        <= pos_d;
    facc_q       <= facc_d;
    cacc_q       <= cacc_d;
    fhave_q      <= fhave_d;
    chave_q      <= chave_d;
    dist_q       <= dist_d;
    res_status_q <= res_status_d;
    res_dist_q   <= res_dist_d;
    ostatus_q    <= ostatus_d;
    odist_q      <= odist_d;
    omax_q       <= omax_d;
    ounb_q       <= ounb_d;
    oseen_q      <= oseen_d;
  end

  assign pos_o   = pos_q;
  assign count_o = count_q;

  assign out_o.valid            = ovalid_q;
  assign out_o.status           = ostatus_q;
  assign out_o.nearest_distance = odist_q;
  assign out_o.max_distance     = omax_q;
  assign out_o.max_unbounded    = ounb_q;
  assign out_o.max_valid        = oseen_q;

  `NSDM_ASSERT(a_count_bound, count_q <= DEPTH_C, "entry count beyond store depth")
  `NSDM_ASSERT(a_full_holds, (state_q == S_EXEC && op_q == OP_INSERT && count_q == DEPTH_C) |=> (count_q == DEPTH_C), "dropped insert changed the count")
  `NSDM_ASSERT(a_max_mono, !(state_q == S_EXEC && op_q == OP_CLEAR) |=> (max_q >= $past(max_q)), "running maximum fell without a clear")

endmodule
`default_nettype wire

// File: bench/nsdm_checker.sv
// Scoreboard for the nearest sorted distance block: watches both channels and predicts results.
// Depends on nsdm_pkg and the channel interfaces in nsdm_ifs.
`default_nettype none
module nsdm_checker #(
  parameter int STORE_DEPTH = nsdm_pkg::DEF_STORE_DEPTH,
  parameter int POS_WIDTH   = nsdm_pkg::DEF_POS_WIDTH
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  nsdm_in_if   in_mon,
  nsdm_out_if  out_mon,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o
);
  import nsdm_pkg::*;

  typedef logic [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    status_e status;
    pos_t    nearest;
    pos_t    peak;
    logic    unbounded;
    logic    seen;
  } outcome_t;

  // Shadow of the heater store, kept ascending.
  pos_t        heaters [STORE_DEPTH];
  int unsigned fill;
  pos_t        peak;
  logic        unbounded;
  logic        seen;
  outcome_t    owed_q [$];

  // Count stored heaters below x, or not above x when inclusive.
  function automatic int unsigned rank_of(pos_t x, bit inclusive);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = fill;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (inclusive ? (heaters[mid] <= x) : (heaters[mid] < x)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one item to the shadow state and return the result it causes.
  function automatic outcome_t predict_outcome(logic [1:0] op, pos_t pos);
    outcome_t    res;
    int unsigned at;
    int unsigned le;
    int unsigned lt;
    bit          have;
    pos_t        best;
    pos_t        d;
    res.status  = ST_OK;
    res.nearest = '0;
    case (op)
      OP_CLEAR: begin
        fill      = 0;
        peak      = '0;
        unbounded = 1'b0;
        seen      = 1'b0;
      end
      OP_INSERT: begin
        if (fill >= STORE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // Equal entries stay ahead of the new one.
          at = rank_of(pos, 1'b1);
          for (int unsigned i = fill; i > at; i--) heaters[i] = heaters[i-1];
          heaters[at] = pos;
          fill++;
        end
      end
      OP_QUERY: begin
        seen = 1'b1;
        if (fill == 0) begin
          res.status = ST_EMPTY;
          unbounded  = 1'b1;
        end else begin
          le   = rank_of(pos, 1'b1);
          lt   = rank_of(pos, 1'b0);
          have = 1'b0;
          best = '0;
          if (le > 0) begin
            best = pos - heaters[le-1];
            have = 1'b1;
          end
          if (lt < fill) begin
            d = heaters[lt] - pos;
            if (!have || d < best) best = d;
          end
          res.nearest = best;
          if (best > peak) peak = best;
        end
      end
      default: ;
    endcase
    res.peak      = peak;
    res.unbounded = unbounded;
    res.seen      = seen;
    return res;
  endfunction

  task automatic report_mismatch(string what, pos_t got, pos_t want);
    if (mismatches_o < 100)
      $display("scoreboard: result %0d %s: got %0h, predicted %0h", checked_o, what, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      fill      = 0;
      peak      = '0;
      unbounded = 1'b0;
      seen      = 1'b0;
      owed_q.delete();
      mismatches_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("arrived with nothing outstanding", pos_t'(out_mon.status), '0);
        end else begin
          want = owed_q.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch("status", pos_t'(out_mon.status), pos_t'(want.status));
          if (out_mon.nearest_distance !== want.nearest)
            report_mismatch("nearest_distance", out_mon.nearest_distance, want.nearest);
          if (out_mon.max_distance !== want.peak)
            report_mismatch("max_distance", out_mon.max_distance, want.peak);
          if (out_mon.max_unbounded !== want.unbounded)
            report_mismatch("max_unbounded", pos_t'(out_mon.max_unbounded),
                            pos_t'(want.unbounded));
          if (out_mon.max_valid !== want.seen)
            report_mismatch("max_valid", pos_t'(out_mon.max_valid), pos_t'(want.seen));
        end
        checked_o++;
      end
      if (in_mon.valid && in_mon.ready)
        owed_q.push_back(predict_outcome(in_mon.opcode, in_mon.position));
      pending_o = owed_q.size();
    end
  end

endmodule
`default_nettype wire

// File: bench/nearest_sorted_distance_max_top_test.sv
// Top of the bench for nearest_sorted_distance_max_top: clock, reset, stimulus and verdict.
// Depends on nsdm_pkg, nsdm_ifs, the block itself and the nsdm_checker scoreboard.
`default_nettype none
module nearest_sorted_distance_max_top_test;
  import nsdm_pkg::*;

  localparam int STORE_DEPTH = DEF_STORE_DEPTH;
  localparam int POS_WIDTH   = DEF_POS_WIDTH;

  typedef logic [POS_WIDTH-1:0] pos_t;

  // Opcode that the block answers with an OK status and no change to its state.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam pos_t POS_MAX = '1;

  localparam int MAX_GAP       = 13;
  localparam int HOLD_CYCLES   = 400;
  // Settling time at the end, longer than one query takes to pass.
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 4000;
  // Slowest correct run: ~1300 items, each with the longest random gap on either side
  // and a query's processing, plus two long receiver holds; the limit allows several
  // times over that.
  localparam int CYCLE_LIMIT   = 400000;

  logic clk_i;
  logic rst_ni;

  nsdm_in_if  #(.POS_WIDTH(POS_WIDTH)) in_if ();
  nsdm_out_if #(.POS_WIDTH(POS_WIDTH)) out_if ();

  int mismatches;
  int pending;
  int checked;
  int cycles;

  nearest_sorted_distance_max_top #(
    .STORE_DEPTH (STORE_DEPTH),
    .POS_WIDTH   (POS_WIDTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  nsdm_checker #(
    .STORE_DEPTH (STORE_DEPTH),
    .POS_WIDTH   (POS_WIDTH)
  ) scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Stimulus bookkeeping: what the store should hold, only to steer the item mix.
  int   stored;
  pos_t cluster_base;
  pos_t hist [$];
  bit   send_calm;
  int   n_clear, n_insert, n_dropped, n_query, n_unfound, n_ignored;

  // Offer one item at the falling edge, after a random gap, and hold it until accepted.
  // A zero gap keeps valid high and only swaps the payload.
  task automatic send_item(input logic [1:0] op, input pos_t pos);
    int gap;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid    = 1'b1;
    in_if.opcode   = op;
    in_if.position = pos;
    do @(posedge clk_i); while (!in_if.ready);
    case (op)
      OP_CLEAR: begin
        n_clear++;
        stored = 0;
      end
      OP_INSERT: begin
        n_insert++;
        if (stored < STORE_DEPTH) stored++;
        else n_dropped++;
        hist.push_back(pos);
        if (hist.size() > 64) void'(hist.pop_front());
      end
      OP_QUERY: begin
        n_query++;
        if (stored == 0) n_unfound++;
      end
      default: n_ignored++;
    endcase
    @(negedge clk_i);
  endtask

  function automatic pos_t pick_extreme();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return POS_MAX;
      2:       return pos_t'(1);
      default: return POS_MAX - 1;
    endcase
  endfunction

  // Heater positions: wide spread, a dense cluster for duplicates, extremes, repeats.
  function automatic pos_t pick_heater();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    if (r < 75) return cluster_base + $urandom_range(0, 255);
    if (r < 85) return pick_extreme();
    if (hist.size() > 0) return hist[$urandom_range(0, hist.size() - 1)];
    return $urandom;
  endfunction

  // Query points: anywhere, right on or beside a recent heater, extremes, the cluster.
  function automatic pos_t pick_point();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35 || hist.size() == 0) return $urandom;
    if (r < 65) return hist[$urandom_range(0, hist.size() - 1)] + $urandom_range(0, 6) - 3;
    if (r < 75) return pick_extreme();
    return cluster_base + $urandom_range(0, 300);
  endfunction

  // Receiver: random stalls per result, with two long holds so the block backs up.
  initial begin : receiver
    int gap;
    int taken;
    bit calm;
    out_if.ready = 1'b0;
    taken = 0;
    calm  = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == 30 || taken == 600) begin
        // Hold off while the sender keeps offering items.
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if ($urandom_range(0, 31) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("watchdog: cycle limit of %0d reached", CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int          drain;
    int unsigned r;
    in_if.valid    = 1'b0;
    in_if.opcode   = OP_CLEAR;
    in_if.position = '0;
    rst_ni         = 1'b0;
    stored         = 0;
    send_calm      = 1'b0;
    cluster_base   = $urandom;
    {n_clear, n_insert, n_dropped, n_query, n_unfound, n_ignored} = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: query straight out of reset finds nothing and makes the max unbounded.
    send_item(OP_QUERY, pos_t'(1234));
    send_item(OP_UNUSED, '0);
    send_item(OP_CLEAR, '0);
    // Heaters at both ends of the range; distances up to half the range.
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, POS_MAX);
    send_item(OP_QUERY, '0);
    send_item(OP_QUERY, POS_MAX);
    send_item(OP_QUERY, pos_t'(32'h7FFF_FFFF));
    send_item(OP_QUERY, pos_t'(32'h8000_0000));
    // Duplicates, an exact hit and a tie between floor and ceiling.
    send_item(OP_INSERT, pos_t'(100));
    send_item(OP_INSERT, pos_t'(100));
    send_item(OP_INSERT, pos_t'(50));
    send_item(OP_QUERY, pos_t'(100));
    send_item(OP_QUERY, pos_t'(75));
    send_item(OP_QUERY, pos_t'(101));
    send_item(OP_UNUSED, POS_MAX);
    // Lone heater: one query with no floor, one with no ceiling.
    send_item(OP_CLEAR, POS_MAX);
    send_item(OP_INSERT, pos_t'(32'h8000_0000));
    send_item(OP_QUERY, '0);
    send_item(OP_QUERY, POS_MAX);
    // Empty query after a clear; the unbounded flag must stick past later hits.
    send_item(OP_CLEAR, '0);
    send_item(OP_QUERY, pos_t'(5));
    send_item(OP_INSERT, pos_t'(10));
    send_item(OP_QUERY, pos_t'(3));

    // Short rounds over small stores, with stray clears and unused opcodes mixed in.
    repeat (2) begin
      cluster_base = $urandom;
      send_item(OP_CLEAR, $urandom);
      repeat (20) begin
        r = $urandom_range(0, 99);
        if (r < 45)      send_item(OP_INSERT, pick_heater());
        else if (r < 90) send_item(OP_QUERY, pick_point());
        else if (r < 95) send_item(OP_UNUSED, $urandom);
        else             send_item(OP_CLEAR, $urandom);
      end
    end

    // Pause until every result is back before the long fill.
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);

    // Fill the store to the top, querying along the way so the search runs at many sizes.
    cluster_base = $urandom;
    send_item(OP_CLEAR, '0);
    while (stored < STORE_DEPTH) begin
      r = $urandom_range(0, 99);
      if (r < 89)      send_item(OP_INSERT, pick_heater());
      else if (r < 98) send_item(OP_QUERY, pick_point());
      else             send_item(OP_UNUSED, $urandom);
    end
    // Full store: inserts are refused, queries see all entries.
    repeat (30) begin
      r = $urandom_range(0, 99);
      if (r < 25)      send_item(OP_INSERT, pick_heater());
      else if (r < 95) send_item(OP_QUERY, pick_point());
      else             send_item(OP_UNUSED, $urandom);
    end
    send_item(OP_CLEAR, $urandom);
    send_item(OP_QUERY, $urandom);

    // Drain, then let the block settle before the verdict.
    in_if.valid = 1'b0;
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Covered %0d clears, %0d inserts (%0d refused on a full store), %0d queries",
             n_clear, n_insert, n_dropped, n_query);
    $display("(%0d on an empty store), %0d unused opcodes; %0d results checked, %0d left over.",
             n_unfound, n_ignored, checked, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
